[src/chacha_stream_cipher_unit_defines.svh]
// Assertion macros for the ChaCha stream cipher unit.
// Used by the port checker; no other dependencies.
`ifndef CHACHA_STREAM_CIPHER_UNIT_DEFINES_SVH
`define CHACHA_STREAM_CIPHER_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define CSC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define CSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/chacha_pkg.sv]
// Shared types, constants and helpers for the ChaCha stream cipher unit.
// No dependencies.
package chacha_pkg;

    localparam int unsigned CfgCount = 8;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned QueueDepth = 2;

    typedef enum logic [1:0] {
        REQ_DATA  = 2'd0,
        REQ_SET   = 2'd1,
        REQ_LOAD  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        CFG_KEY0   = 3'd0,
        CFG_KEY1   = 3'd1,
        CFG_KEY2   = 3'd2,
        CFG_KEY3   = 3'd3,
        CFG_NONCE0 = 3'd4,
        CFG_NONCE1 = 3'd5,
        CFG_NONCE2 = 3'd6,
        CFG_SET    = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        NSZ_64  = 2'd0,
        NSZ_96  = 2'd1,
        NSZ_128 = 2'd2,
        NSZ_192 = 2'd3
    } nonce_size_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINISH,
        ST_OUT
    } core_state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] data_in;
        logic        end_of_message;
        logic [63:0] block_number;
    } in_item_t;

    typedef struct packed {
        logic [63:0] data_out;
        logic        last_of_message;
    } out_item_t;

    typedef logic [15:0][31:0] cc_state_t;

    function automatic logic [31:0] sigma_word(input logic key256, input logic [1:0] i);
        logic [31:0] w;
        case (i)
            2'd0: w = 32'h61707865;
            2'd1: w = key256 ? 32'h3320646e : 32'h3120646e;
            2'd2: w = key256 ? 32'h79622d32 : 32'h79622d36;
            default: w = 32'h6b206574;
        endcase
        return w;
    endfunction

    function automatic logic [127:0] qr(input logic [127:0] v);
        logic [31:0] a, b, c, d;
        a = v[31:0]; b = v[63:32]; c = v[95:64]; d = v[127:96];
        a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
        c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
        a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
        c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
        return {d, c, b, a};
    endfunction

endpackage

[src/chacha_stream_cipher_unit.sv]
// ChaCha/XChaCha stream cipher unit: a data word that starts a keystream block passes
// the iterative round core (ROUND, FINISH, OUT); the block's other seven words use the
// stored keystream. No request is taken while the core computes a block or subkey.
// Set and load requests are taken in IDLE; an XChaCha load also runs ROUND and FINISH.
// Synchronous active-low reset clears control, counter, key and restores settings to 3.
// Depends on chacha_pkg, chacha_front and chacha_back.
module chacha_stream_cipher_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [63:0]           cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  chacha_pkg::in_item_t  s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output chacha_pkg::out_item_t m_item
);
    import chacha_pkg::*;

    logic             q_valid, q_ready;
    in_item_t         q_item;
    logic [7:0][63:0] regs;

    chacha_front u_front (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_item,
        .q_valid, .q_ready, .q_item, .regs
    );

    chacha_back u_back (
        .aclk, .aresetn, .regs,
        .q_valid, .q_ready, .q_item,
        .m_valid, .m_ready, .m_item
    );
endmodule

[src/chacha_front.sv]
// Front end: configuration registers, request queue toward the round core.
// Depends on chacha_pkg.
module chacha_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  chacha_pkg::in_item_t s_item,
    output logic                 q_valid,
    input  logic                 q_ready,
    output chacha_pkg::in_item_t q_item,
    output logic [7:0][63:0]     regs
);
    import chacha_pkg::*;

    logic [7:0][63:0] regs_reg;
    in_item_t         q_mem [QueueDepth];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic             push, pop;

    assign regs    = regs_reg;
    assign s_ready = (cnt_reg != 2'(QueueDepth));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = q_mem[rd_ptr_reg];
    // unknown requests never enter the queue
    assign push    = s_valid && s_ready && (s_item.req_type != REQ_NONE);
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg <= '0;
            regs_reg[CFG_SET] <= 64'd3;
        end else if (cfg_we) begin
            if (cfg_index == CFG_SET) regs_reg[CFG_SET] <= {57'd0, cfg_data[6:0]};
            else regs_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_mem[wr_ptr_reg] <= s_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

[src/chacha_back.sv]
// Back end: iterative ChaCha round core, keystream block, counter and output register.
// Depends on chacha_pkg.
module chacha_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [7:0][63:0]      regs,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  chacha_pkg::in_item_t  q_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output chacha_pkg::out_item_t m_item
);
    import chacha_pkg::*;

    core_state_t      state_reg, state_next;
    cc_state_t        x_reg, x_next, init_v;
    logic [15:0][31:0] ks_reg;
    logic [7:0][31:0] key_reg;
    logic [31:0]      ctr_lo_reg, ctr_hi_reg;
    logic [1:0][31:0] tail_reg;
    logic [2:0]       pos_reg;
    logic [4:0]       half_reg;      // half double-round counter
    logic             xmode_reg;     // HChaCha subkey derivation in progress
    logic             out_valid_reg;
    out_item_t        out_reg;
    logic [3:0]       dr_cfg;
    logic [4:0]       half_total;
    logic             key256;
    logic [1:0]       nsz;
    logic [15:0][31:0] nw;
    logic [7:0][31:0] key_cfg;
    logic             take, need_block, start_x, start_b, emit;
    logic [63:0]      ksw;

    assign key256 = regs[CFG_SET][0];
    assign nsz    = regs[CFG_SET][2:1];
    assign dr_cfg = regs[CFG_SET][6:3];
    assign half_total = (dr_cfg == 4'd0) ? 5'd20 : {dr_cfg, 1'b0};

    always_comb begin
        for (int i = 0; i < 16; i++) nw[i] = regs[i >> 1][(i & 1) * 32 +: 32];
        for (int i = 0; i < 8; i++) key_cfg[i] = key256 ? nw[i] : nw[i & 3];
    end

    // queue head is taken in IDLE; a data word needing a new block stays at the
    // head through the rounds and is popped when its result is written
    assign take       = (state_reg == ST_IDLE) && q_valid && (!out_valid_reg || m_ready);
    assign need_block = (pos_reg == 3'd0);
    assign start_x    = take && (q_item.req_type == REQ_LOAD) && (nsz == NSZ_192);
    assign start_b    = take && (q_item.req_type == REQ_DATA) && need_block;
    assign q_ready    = (take && !start_b) || (state_reg == ST_OUT);
    assign m_valid    = out_valid_reg;
    assign m_item     = out_reg;

    always_comb begin
        for (int i = 0; i < 4; i++) init_v[i] = sigma_word(key256, 2'(i));
        if (start_x) begin
            for (int i = 0; i < 8; i++) init_v[4 + i] = key_cfg[i];
            for (int i = 0; i < 4; i++) init_v[12 + i] = nw[8 + i];
        end else begin
            for (int i = 0; i < 8; i++) init_v[4 + i] = key_reg[i];
            init_v[12] = ctr_lo_reg;
            init_v[13] = ctr_hi_reg;
            init_v[14] = tail_reg[0];
            init_v[15] = tail_reg[1];
        end
    end

    // one column or diagonal round per cycle
    always_comb begin
        logic [127:0] r0, r1, r2, r3;
        x_next = x_reg;
        if (!half_reg[0]) begin
            r0 = qr({x_reg[12], x_reg[8],  x_reg[4], x_reg[0]});
            r1 = qr({x_reg[13], x_reg[9],  x_reg[5], x_reg[1]});
            r2 = qr({x_reg[14], x_reg[10], x_reg[6], x_reg[2]});
            r3 = qr({x_reg[15], x_reg[11], x_reg[7], x_reg[3]});
            {x_next[12], x_next[8],  x_next[4], x_next[0]} = r0;
            {x_next[13], x_next[9],  x_next[5], x_next[1]} = r1;
            {x_next[14], x_next[10], x_next[6], x_next[2]} = r2;
            {x_next[15], x_next[11], x_next[7], x_next[3]} = r3;
        end else begin
            r0 = qr({x_reg[15], x_reg[10], x_reg[5], x_reg[0]});
            r1 = qr({x_reg[12], x_reg[11], x_reg[6], x_reg[1]});
            r2 = qr({x_reg[13], x_reg[8],  x_reg[7], x_reg[2]});
            r3 = qr({x_reg[14], x_reg[9],  x_reg[4], x_reg[3]});
            {x_next[15], x_next[10], x_next[5], x_next[0]} = r0;
            {x_next[12], x_next[11], x_next[6], x_next[1]} = r1;
            {x_next[13], x_next[8],  x_next[7], x_next[2]} = r2;
            {x_next[14], x_next[9],  x_next[4], x_next[3]} = r3;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (start_x || start_b) state_next = ST_ROUND;
            ST_ROUND:  if (half_reg == half_total - 5'd1) state_next = ST_FINISH;
            ST_FINISH: state_next = xmode_reg ? ST_IDLE : ST_OUT;
            ST_OUT:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign ksw  = {ks_reg[{pos_reg, 1'b1}], ks_reg[{pos_reg, 1'b0}]};
    assign emit = (state_reg == ST_OUT) ||
                  (take && (q_item.req_type == REQ_DATA) && !need_block);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            key_reg       <= '0;
            ctr_lo_reg    <= '0;
            ctr_hi_reg    <= '0;
            tail_reg      <= '0;
            pos_reg       <= 3'd0;
            half_reg      <= 5'd0;
            xmode_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_ready) out_valid_reg <= 1'b0;
            if (take) begin
                case (q_item.req_type)
                    REQ_SET: begin
                        ctr_lo_reg <= q_item.block_number[31:0];
                        if (nsz != NSZ_96) ctr_hi_reg <= q_item.block_number[63:32];
                        pos_reg <= 3'd0;
                    end
                    REQ_LOAD: begin
                        key_reg <= key_cfg;
                        pos_reg <= 3'd0;
                        ctr_lo_reg <= '0;
                        ctr_hi_reg <= '0;
                        case (nsz)
                            NSZ_64:  tail_reg <= {nw[9], nw[8]};
                            NSZ_96: begin
                                ctr_hi_reg <= nw[8];
                                tail_reg   <= {nw[10], nw[9]};
                            end
                            NSZ_128: begin
                                ctr_lo_reg <= nw[8];
                                ctr_hi_reg <= nw[9];
                                tail_reg   <= {nw[11], nw[10]};
                            end
                            default: tail_reg <= {nw[13], nw[12]};
                        endcase
                    end
                    default: ;
                endcase
            end
            if (start_x || start_b) begin
                half_reg  <= 5'd0;
                xmode_reg <= start_x;
            end else if (state_reg == ST_ROUND) begin
                half_reg <= half_reg + 5'd1;
            end
            if (state_reg == ST_FINISH && xmode_reg) begin
                key_reg[3:0] <= x_reg[3:0];
                key_reg[7:4] <= x_reg[15:12];
            end
            if (state_reg == ST_FINISH && !xmode_reg) begin
                ctr_lo_reg <= ctr_lo_reg + 32'd1;
                if (ctr_lo_reg == 32'hffffffff && nsz != NSZ_96)
                    ctr_hi_reg <= ctr_hi_reg + 32'd1;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
                pos_reg <= q_item.end_of_message ? 3'd0 : pos_reg + 3'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (start_x || start_b) x_reg <= init_v;
        else if (state_reg == ST_ROUND) x_reg <= x_next;
        if (state_reg == ST_FINISH && !xmode_reg) begin
            for (int i = 0; i < 16; i++) ks_reg[i] <= x_reg[i] + init_v[i];
        end
        if (emit) begin
            out_reg.data_out        <= q_item.data_in ^ ksw;
            out_reg.last_of_message <= q_item.end_of_message;
        end
    end
endmodule

[src/chacha_checker.sv]
// Port-level checker for the ChaCha stream cipher unit, bound to the top level.
// Depends on chacha_pkg and chacha_stream_cipher_unit_defines.svh.
`include "chacha_stream_cipher_unit_defines.svh"
module chacha_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input chacha_pkg::in_item_t  s_item,
    input logic                  m_valid,
    input logic                  m_ready,
    input chacha_pkg::out_item_t m_item
);
    import chacha_pkg::*;

    `CSC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item), "result changed while stalled")
    `CSC_ASSERT_NEXT(a_reset_idle, aclk, 1'b1, !aresetn, !m_valid, "result valid after reset")
    `CSC_ASSERT_IMP(a_ready_after_reset, aclk, aresetn, $rose(aresetn), s_ready, "input not ready after reset")
endmodule

bind chacha_stream_cipher_unit chacha_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .s_item, .m_valid, .m_ready, .m_item
);
